/* design/wct_pkg.sv */
package wct_pkg;

    // Field widths of the ports
    localparam int SAMPLE_W   = 32;
    localparam int THR_W      = 16;
    localparam int CNT_W      = 5;
    localparam int MASK_OUT_W = 16;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = SAMPLE_W + THR_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 2'd2;

    // Action codes reported with each result
    localparam logic [ACT_W-1:0] ACT_SKIP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIRST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RISE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FALL  = 2'd3;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_CLASSIFY,
        OP_WALK,
        OP_SAVE,
        OP_EMIT,
        OP_RSY_INIT,
        OP_COUNT
    } t_op;

    // Branch conditions of the sequencer
    typedef enum logic [2:0] {
        C_JUMP,
        C_IDLE,
        C_ZERO,
        C_LOOP,
        C_OUT
    } t_cond;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_IDLE      = 3'd0;
    localparam t_pc PC_LOAD      = 3'd1;
    localparam t_pc PC_CLASSIFY  = 3'd2;
    localparam t_pc PC_WALK      = 3'd3;
    localparam t_pc PC_SAVE      = 3'd4;
    localparam t_pc PC_EMIT      = 3'd5;
    localparam t_pc PC_RSY_INIT  = 3'd6;
    localparam t_pc PC_RSY_COUNT = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic resync;
        logic zero;
        logic more;
        logic out_free;
    } t_stat;

    // Control from the sequencer
    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctrl;

    // Microprogram store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:      w = '{op: OP_NOP,      cond: C_IDLE, target: PC_IDLE};
            PC_LOAD:      w = '{op: OP_MUL,      cond: C_ZERO, target: PC_EMIT};
            PC_CLASSIFY:  w = '{op: OP_CLASSIFY, cond: C_JUMP, target: PC_WALK};
            PC_WALK:      w = '{op: OP_WALK,     cond: C_LOOP, target: PC_SAVE};
            PC_SAVE:      w = '{op: OP_SAVE,     cond: C_JUMP, target: PC_EMIT};
            PC_EMIT:      w = '{op: OP_EMIT,     cond: C_OUT,  target: PC_IDLE};
            PC_RSY_INIT:  w = '{op: OP_RSY_INIT, cond: C_JUMP, target: PC_RSY_COUNT};
            PC_RSY_COUNT: w = '{op: OP_COUNT,    cond: C_LOOP, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* design/wct_seq.sv */
module wct_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wct_pkg::t_stat i_stat,
    output wct_pkg::t_ctrl o_ctrl
);

    wct_pkg::t_pc    r_pc;
    wct_pkg::t_pc    n_pc;
    wct_pkg::t_uword w_word;

    assign w_word      = wct_pkg::ucode(r_pc);
    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.idle = (r_pc == wct_pkg::PC_IDLE);

    // Hold the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= wct_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Pick the next step from the branch condition
    always_comb begin
        n_pc = r_pc;
        unique case (w_word.cond)
            wct_pkg::C_JUMP: n_pc = w_word.target;
            wct_pkg::C_IDLE: begin
                if (i_stat.resync) begin
                    n_pc = wct_pkg::PC_RSY_INIT;
                end else if (i_stat.in_fire) begin
                    n_pc = wct_pkg::PC_LOAD;
                end else begin
                    n_pc = w_word.target;
                end
            end
            wct_pkg::C_ZERO: n_pc = i_stat.zero ? w_word.target : r_pc + 3'd1;
            wct_pkg::C_LOOP: n_pc = i_stat.more ? r_pc : w_word.target;
            wct_pkg::C_OUT:  n_pc = i_stat.out_free ? w_word.target : r_pc;
            default:         n_pc = wct_pkg::PC_IDLE;
        endcase
    end

endmodule

/* design/wct_dp.sv */
module wct_dp #(
    parameter int MAX_WORKERS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wct_pkg::t_ctrl                      i_ctrl,
    input  logic                                i_in_fire,
    input  logic [wct_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [$clog2(MAX_WORKERS+1)-1:0]    i_n,
    input  logic [wct_pkg::CNT_W-1:0]           i_step,
    input  logic [wct_pkg::THR_W-1:0]           i_thr,
    output logic                                o_zero,
    output logic                                o_more,
    output logic [MAX_WORKERS-1:0]              o_mask,
    output logic [$clog2(MAX_WORKERS+1)-1:0]    o_awake,
    output logic [wct_pkg::ACT_W-1:0]           o_action,
    output logic [$clog2(MAX_WORKERS+1)-1:0]    o_changed
);

    localparam int NW    = $clog2(MAX_WORKERS + 1);
    localparam int IDXW  = $clog2(MAX_WORKERS);
    localparam int CMPW  = (NW > wct_pkg::CNT_W) ? NW : wct_pkg::CNT_W;
    localparam int RST_N = (16 < MAX_WORKERS) ? 16 : MAX_WORKERS;

    logic [wct_pkg::SAMPLE_W-1:0] r_sample;
    logic [wct_pkg::SAMPLE_W-1:0] r_prev;
    logic [wct_pkg::PROD_W-1:0]   r_prod;
    logic [MAX_WORKERS-1:0]       r_mask;
    logic [NW-1:0]                r_awake;
    logic [NW-1:0]                r_idx;
    logic [NW-1:0]                r_changed;
    logic [wct_pkg::ACT_W-1:0]    r_action;

    logic                         w_bit;
    logic                         w_room;
    logic                         w_up;
    logic                         w_flip;
    logic                         w_rise;
    logic [wct_pkg::THR_W:0]      w_scale;
    logic [MAX_WORKERS-1:0]       w_keep;

    assign w_bit   = r_mask[r_idx[IDXW-1:0]];
    assign w_room  = CMPW'(r_changed) < CMPW'(i_step);
    assign w_up    = (r_action == wct_pkg::ACT_RISE);
    assign w_flip  = w_up ? w_bit : (!w_bit && (r_awake > NW'(1)));
    assign w_scale = {1'b1, i_thr};
    assign w_rise  = wct_pkg::PROD_W'({r_sample, 16'h0000}) > r_prod;
    assign o_zero  = (r_sample == '0);

    // Keep workers 1 .. n-1 on a worker count change
    always_comb begin
        for (int i = 0; i < MAX_WORKERS; i++) begin
            w_keep[i] = (i != 0) && (NW'(i) < i_n);
        end
    end

    // Flag whether the walk goes on
    always_comb begin
        case (i_ctrl.op)
            wct_pkg::OP_WALK:  o_more = w_room && (w_up ? (r_idx < i_n) : (r_idx != '0));
            wct_pkg::OP_COUNT: o_more = (r_idx < i_n);
            default:           o_more = 1'b0;
        endcase
    end

    // Update the sleep mask, awake count and previous sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_awake <= NW'(RST_N);
            r_prev  <= '0;
        end else begin
            case (i_ctrl.op)
                wct_pkg::OP_WALK: begin
                    if (o_more && w_flip) begin
                        r_mask[r_idx[IDXW-1:0]] <= !w_up;
                        r_awake <= w_up ? r_awake + NW'(1) : r_awake - NW'(1);
                    end
                end
                wct_pkg::OP_SAVE: r_prev <= r_sample;
                wct_pkg::OP_RSY_INIT: begin
                    r_mask  <= r_mask & w_keep;
                    r_awake <= '0;
                end
                wct_pkg::OP_COUNT: begin
                    if (o_more && !w_bit) begin
                        r_awake <= r_awake + NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance the walk index, counters and product
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_sample <= i_sample;
        end
        case (i_ctrl.op)
            wct_pkg::OP_MUL: begin
                r_prod    <= wct_pkg::PROD_W'(r_prev) * wct_pkg::PROD_W'(w_scale);
                r_action  <= wct_pkg::ACT_SKIP;
                r_changed <= '0;
            end
            wct_pkg::OP_CLASSIFY: begin
                r_changed <= '0;
                if (r_prev == '0) begin
                    r_action <= wct_pkg::ACT_FIRST;
                    r_idx    <= i_n - NW'(1);
                end else if (w_rise) begin
                    r_action <= wct_pkg::ACT_RISE;
                    r_idx    <= NW'(1);
                end else begin
                    r_action <= wct_pkg::ACT_FALL;
                    r_idx    <= i_n - NW'(1);
                end
            end
            wct_pkg::OP_WALK: begin
                if (o_more) begin
                    r_idx <= w_up ? r_idx + NW'(1) : r_idx - NW'(1);
                    if (w_flip) begin
                        r_changed <= r_changed + NW'(1);
                    end
                end
            end
            wct_pkg::OP_RSY_INIT: r_idx <= '0;
            wct_pkg::OP_COUNT: begin
                if (o_more) begin
                    r_idx <= r_idx + NW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_mask    = r_mask;
    assign o_awake   = r_awake;
    assign o_action  = r_action;
    assign o_changed = r_changed;

endmodule

/* design/worker_concurrency_throttle.sv */
// Worker concurrency throttle: takes one energy-per-instruction sample (unsigned
// Q16.16, zero skipped) per transfer and returns one result with the sleep mask,
// awake count, action and number of workers changed. A small microprogram walks
// the workers one index per cycle, and takes no new sample until the result of
// the last one has been loaded into the output register. Writing worker_count
// starts a recount pass that holds off both samples and further writes until it
// completes; configuration is written only while idle.
module worker_concurrency_throttle #(
    parameter int MAX_WORKERS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [wct_pkg::SAMPLE_W-1:0]     i_sample_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wct_pkg::MASK_OUT_W-1:0]   o_sleep_mask,
    output logic [wct_pkg::CNT_W-1:0]        o_active_count,
    output logic [wct_pkg::ACT_W-1:0]        o_action_taken,
    output logic [wct_pkg::CNT_W-1:0]        o_changed_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NW   = $clog2(MAX_WORKERS + 1);
    localparam int CMPW = (NW > wct_pkg::CNT_W) ? NW : wct_pkg::CNT_W;

    // Clamp the worker count to 1 .. MAX_WORKERS
    function automatic logic [NW-1:0] clamp_n(input logic [wct_pkg::CNT_W-1:0] v);
        logic [NW-1:0] r;
        if (v == '0) begin
            r = NW'(1);
        end else if (CMPW'(v) > CMPW'(MAX_WORKERS)) begin
            r = NW'(MAX_WORKERS);
        end else begin
            r = NW'(v);
        end
        return r;
    endfunction

    logic [NW-1:0]                  r_n;
    logic [wct_pkg::CNT_W-1:0]      r_step;
    logic [wct_pkg::THR_W-1:0]      r_thr;
    logic                           r_rsy;

    logic                           r_out_valid;
    logic [wct_pkg::MASK_OUT_W-1:0] r_out_mask;
    logic [wct_pkg::CNT_W-1:0]      r_out_active;
    logic [wct_pkg::ACT_W-1:0]      r_out_action;
    logic [wct_pkg::CNT_W-1:0]      r_out_changed;

    wct_pkg::t_ctrl                 w_ctrl;
    wct_pkg::t_stat                 w_stat;
    logic                           w_in_fire;
    logic                           w_cfg_fire;
    logic                           w_out_free;
    logic                           w_emit;
    logic                           w_zero;
    logic                           w_more;
    logic [MAX_WORKERS-1:0]         w_mask;
    logic [NW-1:0]                  w_awake;
    logic [wct_pkg::ACT_W-1:0]      w_action;
    logic [NW-1:0]                  w_changed;
    logic [MAX_WORKERS+wct_pkg::MASK_OUT_W-1:0] w_mask_ext;
    logic [CMPW-1:0]                w_awake_ext;
    logic [CMPW-1:0]                w_changed_ext;

    assign o_cfg_ready = w_ctrl.idle && !r_rsy;
    assign o_ready     = w_ctrl.idle && !r_rsy && !i_cfg_valid;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign w_in_fire   = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_emit      = (w_ctrl.op == wct_pkg::OP_EMIT) && w_out_free;

    assign w_stat.in_fire  = w_in_fire;
    assign w_stat.resync   = r_rsy;
    assign w_stat.zero     = w_zero;
    assign w_stat.more     = w_more;
    assign w_stat.out_free = w_out_free;

    wct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    wct_dp #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_in_fire (w_in_fire),
        .i_sample  (i_sample_value),
        .i_n       (r_n),
        .i_step    (r_step),
        .i_thr     (r_thr),
        .o_zero    (w_zero),
        .o_more    (w_more),
        .o_mask    (w_mask),
        .o_awake   (w_awake),
        .o_action  (w_action),
        .o_changed (w_changed)
    );

    // Take configuration writes; a worker count write requests a recount
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= clamp_n(wct_pkg::CNT_W'(16));
            r_step <= wct_pkg::CNT_W'(4);
            r_thr  <= wct_pkg::THR_W'(6554);
            r_rsy  <= 1'b0;
        end else begin
            if (w_ctrl.op == wct_pkg::OP_RSY_INIT) begin
                r_rsy <= 1'b0;
            end
            if (w_cfg_fire) begin
                case (i_cfg_index)
                    wct_pkg::CFG_WORKER_COUNT: begin
                        r_n   <= clamp_n(i_cfg_data[wct_pkg::CNT_W-1:0]);
                        r_rsy <= 1'b1;
                    end
                    wct_pkg::CFG_STEP_LIMIT:     r_step <= i_cfg_data[wct_pkg::CNT_W-1:0];
                    wct_pkg::CFG_RISE_THRESHOLD: r_thr  <= i_cfg_data[wct_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign w_mask_ext    = {{wct_pkg::MASK_OUT_W{1'b0}}, w_mask};
    assign w_awake_ext   = CMPW'(w_awake);
    assign w_changed_ext = CMPW'(w_changed);

    // Hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_mask    <= w_mask_ext[wct_pkg::MASK_OUT_W-1:0];
            r_out_active  <= w_awake_ext[wct_pkg::CNT_W-1:0];
            r_out_action  <= w_action;
            r_out_changed <= w_changed_ext[wct_pkg::CNT_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sleep_mask    = r_out_mask;
    assign o_active_count  = r_out_active;
    assign o_action_taken  = r_out_action;
    assign o_changed_count = r_out_changed;

endmodule
